@@ rtl/dws_pkg.sv @@
// shared constants, codes and types of the double-ended queue with search
`default_nettype none

package dws_pkg;

   // number of slots in the ring
   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = IDX_W + 1;
   localparam int DATA_W = 32;
   localparam int POS_W  = 7;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_SEARCH     = 3'd4,
      ACT_LIST       = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2,
      STAT_NOTFOUND  = 2'd3
   } status_type;

   // one result handed from the sequencer to the output register
   typedef struct packed {
      logic                     valid;
      status_type               status;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      logic                     last;
   } emit_type;

   // slot at a given offset from a base slot, wrapped round the ring
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/dws_req_if.sv @@
// request channel: action and value with valid/ready handshake
`default_nettype none

interface dws_req_if;
   import dws_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [2:0]               action;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);

endinterface

`default_nettype wire

@@ rtl/dws_rsp_if.sv @@
// response channel: status, value, position and last flag with valid/ready
`default_nettype none

interface dws_rsp_if;
   import dws_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [DATA_W-1:0] result_value;
   logic [POS_W-1:0]         position;
   logic                     last;

   modport source (output valid, output status, output result_value,
                   output position, output last, input ready);
   modport sink   (input valid, input status, input result_value,
                   input position, input last, output ready);

endinterface

`default_nettype wire

@@ rtl/dws_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module dws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/dws_ctrl.sv @@
// sequencer: ring pointers, ram access and the element walk for search and list
`default_nettype none

module dws_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [2:0]                        req_action,
   input  wire logic signed [dws_pkg::DATA_W-1:0] req_value,
   output dws_pkg::emit_type                      emit,
   input  wire logic                              emit_ready
);
   import dws_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_POP    = 5'b00010,
      S_SEARCH = 5'b00100,
      S_LIST   = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         front_ff, front_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   status_type               pend_status_ff, pend_status_in;
   logic [POS_W-1:0]         pend_pos_ff, pend_pos_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [DATA_W-1:0]        rd_data;

   logic                     full;
   logic                     empty;
   logic [IDX_W-1:0]         front_dec;
   logic [CNT_W-1:0]         idx_next;
   logic                     last_idx;
   logic [POS_W-1:0]         cur_pos;

   dws_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign idx_next  = CNT_W'(idx_ff) + 1'b1;
   assign last_idx  = (idx_next == count_ff);
   assign cur_pos   = POS_W'(idx_ff) + 1'b1;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      val_in         = val_ff;
      pend_status_in = pend_status_ff;
      pend_pos_in    = pend_pos_ff;
      wr_en          = 1'b0;
      wr_addr        = ring_add(front_ff, count_ff);
      rd_en          = 1'b0;
      rd_addr        = ring_add(front_ff, idx_next);
      emit           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in      = req_value;
               idx_in      = '0;
               pend_pos_in = '0;
               unique case (req_action)
                  ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                     state_in = S_EMIT;
                     if (full) begin
                        pend_status_in = STAT_OVERFLOW;
                     end else begin
                        pend_status_in = STAT_OK;
                        wr_en          = 1'b1;
                        count_in       = count_ff + 1'b1;
                        if (req_action == ACT_PUSH_FRONT) begin
                           front_in = front_dec;
                           wr_addr  = front_dec;
                        end
                     end
                  end
                  ACT_POP_FRONT, ACT_POP_BACK: begin
                     if (empty) begin
                        pend_status_in = STAT_UNDERFLOW;
                        state_in       = S_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        count_in = count_ff - 1'b1;
                        state_in = S_POP;
                        if (req_action == ACT_POP_FRONT) begin
                           rd_addr  = front_ff;
                           front_in = ring_add(front_ff, CNT_W'(1));
                        end else begin
                           rd_addr = ring_add(front_ff, count_ff - 1'b1);
                        end
                     end
                  end
                  ACT_SEARCH, ACT_LIST: begin
                     if (empty) begin
                        pend_status_in = STAT_UNDERFLOW;
                        state_in       = S_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        state_in = (req_action == ACT_SEARCH) ? S_SEARCH : S_LIST;
                     end
                  end
                  default: begin
                     // unused codes are dropped without a result
                  end
               endcase
            end
         end
         S_POP: begin
            emit.valid  = 1'b1;
            emit.status = STAT_OK;
            emit.value  = rd_data;
            emit.last   = 1'b1;
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end
         S_SEARCH: begin
            if ($signed(rd_data) == val_ff) begin
               pend_status_in = STAT_OK;
               pend_pos_in    = cur_pos;
               state_in       = S_EMIT;
            end else if (last_idx) begin
               pend_status_in = STAT_NOTFOUND;
               state_in       = S_EMIT;
            end else begin
               rd_en  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         S_LIST: begin
            emit.valid    = 1'b1;
            emit.status   = STAT_OK;
            emit.value    = rd_data;
            emit.position = cur_pos;
            emit.last     = last_idx;
            if (emit_ready) begin
               if (last_idx) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en  = 1'b1;
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_EMIT: begin
            emit.valid    = 1'b1;
            emit.status   = pend_status_ff;
            emit.position = pend_pos_ff;
            emit.last     = 1'b1;
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
      idx_ff         <= idx_in;
      val_ff         <= val_in;
      pend_status_ff <= pend_status_in;
      pend_pos_ff    <= pend_pos_in;
   end

endmodule

`default_nettype wire

@@ rtl/deque_with_search_core.sv @@
// top level of the double-ended queue with search: sequencer and response register
//
// req_chan carries one command per transfer: action (push front, push back,
// pop front, pop back, search, list) and a signed 32-bit value used by the
// pushes and by search. rsp_chan carries the results: status, the popped or
// listed value, the 1-based position and a last flag on the final result of
// each command. unused action codes give no result.
// a push is accepted while the sequencer is idle and its status is held in
// S_EMIT until the response register takes it; a pop reads the ring ram and
// returns the data from S_POP. either kind holds the block until its result
// is taken, so the next command waits. search reads one stored element per
// cycle through the same ram read port, stopping at a match or the last one;
// list gives one result per cycle for each element when the receiver keeps up.
// req_chan.ready is high only while the sequencer is idle; one command is
// handled at a time.
// synchronous reset empties the queue and sets the front index to zero; the
// ram contents are not cleared, only occupied slots are ever read.
// when rsp_chan stalls, the result waits in the response register and the
// sequencer holds its current result until that register frees up.
`default_nettype none

module deque_with_search_core (
   input wire logic  clock,
   input wire logic  reset,
   dws_req_if.sink   req_chan,
   dws_rsp_if.source rsp_chan
);
   import dws_pkg::*;

   emit_type                 emit;
   logic                     emit_ready;
   logic                     take;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [POS_W-1:0]         rsp_position_ff;
   logic                     rsp_last_ff;

   dws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_action (req_chan.action),
      .req_value  (req_chan.value),
      .emit       (emit),
      .emit_ready (emit_ready)
   );

   // the register takes a new result when empty or when its transfer completes
   assign emit_ready = !rsp_valid_ff || rsp_chan.ready;
   assign take       = emit.valid && emit_ready;

   always_comb begin
      priority if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         rsp_status_ff   <= emit.status;
         rsp_value_ff    <= emit.value;
         rsp_position_ff <= emit.position;
         rsp_last_ff     <= emit.last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.position     = rsp_position_ff;
   assign rsp_chan.last         = rsp_last_ff;

endmodule

`default_nettype wire
